>>> src/acl_pkg.sv
// Shared types and constants for the autocorrelation-by-lag block.
package acl_pkg;

  localparam int SMP_W  = 16;
  localparam int LAG_W  = 6;
  localparam int VAL_W  = 48;
  localparam int MEAN_W = 32;
  localparam int DEV_W  = 32;
  localparam int STS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 1'b1;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_ZERO_VAR = 2'd1;
  localparam logic [STS_W-1:0] STS_DROPPED = 2'd2;

  typedef logic signed [SMP_W-1:0]  sample_t;
  typedef logic        [LAG_W-1:0]  lag_t;
  typedef logic signed [VAL_W-1:0]  value_t;
  typedef logic signed [MEAN_W-1:0] mean_t;
  typedef logic        [DEV_W-1:0]  dev_t;
  typedef logic        [STS_W-1:0]  status_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_VARPREP,
    ST_VAR,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_ACC,
    ST_DRAIN,
    ST_NDIV_WAIT,
    ST_VDIV,
    ST_VDIV_WAIT,
    ST_OUT
  } state_e;

endpackage

>>> src/acl_if.sv
// Stream channels: sample input and per-lag result output.
interface acl_in_if import acl_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface acl_out_if import acl_pkg::*; ();
  logic    valid;
  logic    ready;
  lag_t    lag;
  value_t  value;
  mean_t   mean;
  dev_t    deviation;
  status_t status;
  logic    final_res;
  modport source (output valid, lag, value, mean, deviation, status, final_res, input ready);
  modport sink   (input valid, lag, value, mean, deviation, status, final_res, output ready);
endinterface

>>> src/acl_div.sv
// Bit-serial signed floor divider, one quotient bit per cycle.
module acl_div import acl_pkg::*; #(
  parameter int DW = 96,
  parameter int VW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic        [VW-1:0] divisor_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quot_o
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             run_q, fix_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    quo_q;
  logic [VW:0]      rem_q;
  logic [VW-1:0]    dvs_q;
  logic [VW:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[VW-1:0], quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DW);
        neg_q <= dividend_i[DW-1];
        quo_q <= dividend_i[DW-1] ? -dividend_i : dividend_i;
        rem_q <= '0;
        dvs_q <= (divisor_i == '0) ? VW'(1) : divisor_i;
      end else if (run_q) begin
        rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q <= 1'b0;
          fix_q <= 1'b1;
        end
      end else if (fix_q) begin
        // floor for negative dividends: round magnitude up on a remainder
        if (neg_q) begin
          quo_q <= -(quo_q + DW'(rem_q != '0));
        end
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> src/autocorrelation_by_lag_top.sv
// Top level: sample store, statistics, lag accumulation and result output.
//
//  channel  dir  payload                                          handshake
//  in_i     in   sample, last                                     valid/ready
//  out_o    out  lag, value, mean, deviation, status, final_res   valid/ready
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i                  write enable
//
// Samples load one per cycle, while in the load state, into a dual-read store.
// The beat with last then holds the input through the statistics (two serial
// divisions and a 32-step square root; a zero variance skips the second and
// the rest for a single result), and per lag through accumulation plus one or
// two serial divisions (DW = log2(depth) + 86).
// Reset clears counters and sets config to its defaults; the store needs no clearing.
// A stalled result holds the block until it is taken.
module autocorrelation_by_lag_top import acl_pkg::*; #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_LAGS    = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  acl_in_if.sink               in_i,
  acl_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SW   = AW + 17;
  localparam int QW   = AW + 31;
  localparam int PW   = CW + QW;
  localparam int ACW  = 68 + CW;
  localparam int DW   = AW + 86;
  localparam int VW   = 64;
  localparam int CXW  = 34;

  state_e state_q, state_d;

  logic [SMP_W-1:0] mem [MAX_SAMPLES];
  logic [SMP_W-1:0] rd_a_q, rd_b_q;

  logic [LAG_W-1:0] max_lag_q;
  logic             center_q;

  logic [CW-1:0]        n_q;
  logic signed [SW-1:0] sum_q;
  logic [QW-1:0]        sumsq_q;
  logic                 ovf_q;

  mean_t         mean_q;
  logic [PW-1:0] p1_q, p2_q;
  logic [2*CW-1:0] n2_q;
  logic [VW-1:0] var_q;
  logic [PW-1:0] dnum;

  logic [VW-1:0] sq_rem_q, sq_res_q, sq_bit_q;
  logic [4:0]    sq_cnt_q;
  logic [VW-1:0] sq_trial;

  lag_t          lag_q, lmax_q;
  logic [CW-1:0] j_q, span;
  logic          v1_q, v2_q, v3_q;
  logic signed [CXW-1:0] ca_q, cb_q;
  logic signed [2*CXW-1:0] prod_q;
  logic signed [ACW-1:0] acc_q;

  lag_t    res_lag_q;
  value_t  res_val_q;
  dev_t    res_dev_q;
  status_t res_sts_q;
  logic    res_fin_q;

  logic                 div_start, div_done;
  logic signed [DW-1:0] div_dvd, div_quot;
  logic [VW-1:0]        div_dvs;

  logic       accept, store_ok, issue, drained;
  value_t     sat_val;
  logic [LAG_W-1:0] lmax_calc;
  logic signed [31:0] xsq;

  acl_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign in_i.ready = (state_q == ST_LOAD);
  assign accept     = in_i.valid && in_i.ready;
  assign store_ok   = 32'(n_q) < MAX_SAMPLES;
  assign xsq        = in_i.sample * in_i.sample;

  assign dnum     = p1_q - p2_q;
  assign span     = CW'(32'(n_q) - 32'(lag_q));
  assign issue    = (state_q == ST_ACC);
  assign drained  = !(v1_q || v2_q || v3_q);
  assign sq_trial = sq_res_q + sq_bit_q;

  // saturate the quotient to the 48-bit result range
  always_comb begin
    if (&div_quot[DW-1:VAL_W-1] || ~|div_quot[DW-1:VAL_W-1]) begin
      sat_val = div_quot[VAL_W-1:0];
    end else if (div_quot[DW-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_comb begin
    lmax_calc = max_lag_q;
    if (32'(max_lag_q) > 32'(n_q) - 32'd1) begin
      lmax_calc = LAG_W'(32'(n_q) - 32'd1);
    end
    if (32'(lmax_calc) > MAX_LAGS - 1) begin
      lmax_calc = LAG_W'(MAX_LAGS - 1);
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lag_q <= LAG_W'(16);
      center_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LAG: max_lag_q <= cfg_data_i;
        CFG_CENTER:  center_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sample store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (accept && store_ok) begin
      mem[n_q[AW-1:0]] <= in_i.sample;
    end
    rd_a_q <= mem[j_q[AW-1:0]];
    rd_b_q <= mem[AW'(32'(j_q) + 32'(lag_q))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (accept && in_i.last) state_d = ST_MEAN;
      end
      ST_MEAN: begin
        div_start = 1'b1;
        div_dvd   = DW'($signed({sum_q, 16'b0}));
        div_dvs   = VW'(n_q);
        state_d   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) state_d = ST_VARPREP;
      end
      ST_VARPREP: state_d = ST_VAR;
      ST_VAR: begin
        if (dnum == '0) begin
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_dvd   = DW'({dnum, 32'b0});
          div_dvs   = VW'(n2_q);
          state_d   = ST_VAR_WAIT;
        end
      end
      ST_VAR_WAIT: begin
        if (div_done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_cnt_q == 5'd31) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (j_q + CW'(1) == span) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drained) begin
          div_start = 1'b1;
          div_dvd   = DW'($signed({acc_q, 16'b0}));
          div_dvs   = VW'(span);
          state_d   = ST_NDIV_WAIT;
        end
      end
      ST_NDIV_WAIT: begin
        if (div_done) state_d = center_q ? ST_VDIV : ST_OUT;
      end
      ST_VDIV: begin
        div_start = 1'b1;
        div_dvd   = div_quot;
        div_dvs   = var_q;
        state_d   = ST_VDIV_WAIT;
      end
      ST_VDIV_WAIT: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_o.ready) state_d = res_fin_q ? ST_LOAD : ST_ACC;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // run state and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      ovf_q   <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;

      if (accept) begin
        if (store_ok) begin
          n_q     <= n_q + CW'(1);
          sum_q   <= sum_q + SW'(in_i.sample);
          sumsq_q <= sumsq_q + QW'(xsq[30:0]);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      unique case (state_q)
        ST_MEAN_WAIT: begin
          if (div_done) mean_q <= div_quot[MEAN_W-1:0];
        end
        ST_VARPREP: begin
          p1_q <= PW'(n_q * sumsq_q);
          p2_q <= PW'(((sum_q < 0) ? -sum_q : sum_q) * ((sum_q < 0) ? -sum_q : sum_q));
          n2_q <= n_q * n_q;
        end
        ST_VAR: begin
          if (dnum == '0) begin
            res_lag_q <= '0;
            res_val_q <= '0;
            res_dev_q <= '0;
            res_sts_q <= STS_ZERO_VAR;
            res_fin_q <= 1'b1;
          end
        end
        ST_VAR_WAIT: begin
          if (div_done) begin
            var_q    <= div_quot[VW-1:0];
            sq_rem_q <= div_quot[VW-1:0];
            sq_res_q <= '0;
            sq_bit_q <= {2'b01, {(VW-2){1'b0}}};
            sq_cnt_q <= '0;
          end
        end
        ST_SQRT: begin
          if (sq_rem_q >= sq_trial) begin
            sq_rem_q <= sq_rem_q - sq_trial;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          sq_cnt_q <= sq_cnt_q + 5'd1;
          lag_q    <= '0;
          lmax_q   <= lmax_calc;
          j_q      <= '0;
          acc_q    <= '0;
        end
        ST_ACC: begin
          j_q <= j_q + CW'(1);
        end
        ST_NDIV_WAIT, ST_VDIV_WAIT: begin
          if (div_done && (state_q == ST_VDIV_WAIT || !center_q)) begin
            res_lag_q <= lag_q;
            res_val_q <= sat_val;
            res_dev_q <= sq_res_q[DEV_W-1:0];
            res_sts_q <= ovf_q ? STS_DROPPED : STS_OK;
            res_fin_q <= (lag_q == lmax_q);
          end
        end
        ST_OUT: begin
          if (out_o.ready) begin
            lag_q <= lag_q + LAG_W'(1);
            j_q   <= '0;
            acc_q <= '0;
            if (res_fin_q) begin
              n_q     <= '0;
              sum_q   <= '0;
              sumsq_q <= '0;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: ;
      endcase

      // lag pipeline: read data -> centered (or raw) operands -> product -> sum
      if (v1_q) begin
        ca_q <= center_q ? (CXW'($signed({rd_a_q, 16'b0})) - CXW'(mean_q))
                         : CXW'($signed(rd_a_q));
        cb_q <= center_q ? (CXW'($signed({rd_b_q, 16'b0})) - CXW'(mean_q))
                         : CXW'($signed(rd_b_q));
      end
      if (v2_q) prod_q <= ca_q * cb_q;
      if (v3_q) acc_q  <= acc_q + ACW'(prod_q);
    end
  end

  assign out_o.valid     = (state_q == ST_OUT);
  assign out_o.lag       = res_lag_q;
  assign out_o.value     = res_val_q;
  assign out_o.mean      = mean_q;
  assign out_o.deviation = res_dev_q;
  assign out_o.status    = res_sts_q;
  assign out_o.final_res = res_fin_q;

endmodule
